/* rtl/core/interval_booking_table_assert.svh */
// Assertion macros for the interval booking table.
`ifndef INTERVAL_BOOKING_TABLE_ASSERT_SVH
`define INTERVAL_BOOKING_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define IBT_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("interval_booking_table: same-cycle check failed");
`define IBT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("interval_booking_table: next-cycle check failed");
`else
`define IBT_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define IBT_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* rtl/core/ibt_pkg.sv */
// Shared codes and controller/datapath interface types for the booking table.
package ibt_pkg;

    localparam logic [1:0] ST_BOOKED  = 2'd0;
    localparam logic [1:0] ST_OVERLAP = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_KUP,
        RD_KDN
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_MERGE,
        WR_EXT_PREV,
        WR_EXT_NEXT,
        WR_NEW,
        WR_MOVE
    } wr_op_t;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       advance;
        logic       cur_set;
        wr_op_t     wr_op;
        logic       k_up_load;
        logic       k_dn_load;
        logic       k_dec;
        logic       k_inc;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       res_load;
        logic [1:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic invalid;
        logic at_end;
        logic overlap;
        logic lies_after;
        logic join_prev;
        logic join_next;
        logic full;
        logic up_done;
        logic dn_done;
    } sts_t;

endpackage

/* rtl/core/ibt_dp.sv */
// Datapath: request registers, interval memory, scan/shift counters, result registers.
module ibt_dp #(
    parameter int MAX_INTERVALS = 64,
    parameter int TIME_BITS     = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      range_start,
    input  logic [31:0]      range_end,
    input  ibt_pkg::cmd_t    cmd,
    output ibt_pkg::sts_t    sts,
    output logic [1:0]       status,
    output logic [6:0]       entries_in_use,
    output logic [$clog2(MAX_INTERVALS+1)-1:0] count
);
    import ibt_pkg::*;

    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int TB = TIME_BITS;

    logic [2*TB-1:0] mem [MAX_INTERVALS];
    logic [2*TB-1:0] rd_data_reg;

    logic [TB-1:0] req_s_reg, req_e_reg;
    logic [TB-1:0] prev_start_reg, prev_end_reg;
    logic          prev_valid_reg, cur_valid_reg;
    logic [CW-1:0] idx_reg, k_reg, count_reg;
    logic [1:0]    status_reg;
    logic [6:0]    entries_reg;

    logic [63:0]   s64, e64;
    logic [TB-1:0] cs, ce;
    logic [CW-1:0] ra_full, wa_full, idx_m1;
    logic [AW-1:0] ra, wa;
    logic [2*TB-1:0] wd;
    logic          wr_en;
    logic [CW:0]   k_p1;
    logic [31:0]   cnt32;

    assign s64    = 64'(range_start);
    assign e64    = 64'(range_end);
    assign cs     = rd_data_reg[2*TB-1:TB];
    assign ce     = rd_data_reg[TB-1:0];
    assign idx_m1 = idx_reg - CW'(1);
    assign k_p1   = {1'b0, k_reg} + (CW+1)'(1);

    assign sts.invalid    = req_s_reg >= req_e_reg;
    assign sts.at_end     = idx_reg == count_reg;
    assign sts.overlap    = (req_s_reg < ce) && (req_e_reg > cs);
    assign sts.lies_after = req_e_reg <= cs;
    assign sts.join_prev  = prev_valid_reg && (prev_end_reg == req_s_reg);
    assign sts.join_next  = cur_valid_reg && (cs == req_e_reg);
    assign sts.full       = count_reg == CW'(MAX_INTERVALS);
    assign sts.up_done    = k_reg == idx_reg;
    assign sts.dn_done    = k_p1 >= {1'b0, count_reg};

    always_comb
    begin
        case (cmd.rd_sel)
            RD_KUP:  ra_full = k_reg - CW'(1);
            RD_KDN:  ra_full = k_p1[CW-1:0];
            default: ra_full = idx_reg;
        endcase
    end
    assign ra = ra_full[AW-1:0];

    always_comb
    begin
        wr_en   = 1'b1;
        wa_full = idx_reg;
        wd      = {req_s_reg, req_e_reg};
        case (cmd.wr_op)
            WR_MERGE:
            begin
                wa_full = idx_m1;
                wd      = {prev_start_reg, ce};
            end
            WR_EXT_PREV:
            begin
                wa_full = idx_m1;
                wd      = {prev_start_reg, req_e_reg};
            end
            WR_EXT_NEXT:
            begin
                wd = {req_s_reg, ce};
            end
            WR_NEW:
            begin
                wd = {req_s_reg, req_e_reg};
            end
            WR_MOVE:
            begin
                wa_full = k_reg;
                wd      = rd_data_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end
    assign wa = wa_full[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wa] <= wd;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_s_reg <= s64[TB-1:0];
            req_e_reg <= e64[TB-1:0];
        end
        if (cmd.advance)
        begin
            prev_start_reg <= cs;
            prev_end_reg   <= ce;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            k_reg          <= '0;
            count_reg      <= '0;
            prev_valid_reg <= 1'b0;
            cur_valid_reg  <= 1'b0;
            status_reg     <= ST_BOOKED;
            entries_reg    <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg        <= '0;
                prev_valid_reg <= 1'b0;
                cur_valid_reg  <= 1'b0;
            end
            else if (cmd.advance)
            begin
                idx_reg        <= idx_reg + CW'(1);
                prev_valid_reg <= 1'b1;
            end
            if (cmd.cur_set)
            begin
                cur_valid_reg <= 1'b1;
            end
            if (cmd.k_up_load)
            begin
                k_reg <= count_reg;
            end
            else if (cmd.k_dn_load)
            begin
                k_reg <= idx_reg;
            end
            else if (cmd.k_dec)
            begin
                k_reg <= k_reg - CW'(1);
            end
            else if (cmd.k_inc)
            begin
                k_reg <= k_p1[CW-1:0];
            end
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.res_load)
            begin
                status_reg  <= cmd.res_status;
                entries_reg <= cnt32[6:0];
            end
        end
    end

    assign cnt32          = 32'(count_reg);
    assign status         = status_reg;
    assign entries_in_use = entries_reg;
    assign count          = count_reg;

endmodule

/* rtl/core/ibt_ctrl.sv */
// Controller: sequences scan, merge decision, shifts and result handoff.
module ibt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  ibt_pkg::sts_t sts,
    output ibt_pkg::cmd_t cmd
);
    import ibt_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHK      = 4'd1;
    localparam logic [3:0] S_RD       = 4'd2;
    localparam logic [3:0] S_CMP      = 4'd3;
    localparam logic [3:0] S_DEC      = 4'd4;
    localparam logic [3:0] S_MV_RD_UP = 4'd5;
    localparam logic [3:0] S_MV_WR_UP = 4'd6;
    localparam logic [3:0] S_NEW_WR   = 4'd7;
    localparam logic [3:0] S_MV_RD_DN = 4'd8;
    localparam logic [3:0] S_MV_WR_DN = 4'd9;
    localparam logic [3:0] S_FIN      = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [1:0] st_reg, st_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd        = '0;
        cmd.rd_sel = RD_IDX;
        cmd.wr_op  = WR_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.invalid)
                begin
                    st_next    = ST_INVALID;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (sts.at_end)
                begin
                    state_next = S_DEC;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.overlap)
                begin
                    st_next    = ST_OVERLAP;
                    state_next = S_FIN;
                end
                else if (sts.lies_after)
                begin
                    cmd.cur_set = 1'b1;
                    state_next  = S_DEC;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_DEC:
            begin
                st_next = ST_BOOKED;
                if (sts.join_prev && sts.join_next)
                begin
                    cmd.wr_op     = WR_MERGE;
                    cmd.k_dn_load = 1'b1;
                    state_next    = S_MV_RD_DN;
                end
                else if (sts.join_prev)
                begin
                    cmd.wr_op  = WR_EXT_PREV;
                    state_next = S_FIN;
                end
                else if (sts.join_next)
                begin
                    cmd.wr_op  = WR_EXT_NEXT;
                    state_next = S_FIN;
                end
                else if (sts.full)
                begin
                    st_next    = ST_FULL;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.k_up_load = 1'b1;
                    state_next    = S_MV_RD_UP;
                end
            end
            S_MV_RD_UP:
            begin
                if (sts.up_done)
                begin
                    state_next = S_NEW_WR;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_KUP;
                    state_next = S_MV_WR_UP;
                end
            end
            S_MV_WR_UP:
            begin
                cmd.wr_op  = WR_MOVE;
                cmd.k_dec  = 1'b1;
                state_next = S_MV_RD_UP;
            end
            S_NEW_WR:
            begin
                cmd.wr_op   = WR_NEW;
                cmd.cnt_inc = 1'b1;
                state_next  = S_FIN;
            end
            S_MV_RD_DN:
            begin
                if (sts.dn_done)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_KDN;
                    state_next = S_MV_WR_DN;
                end
            end
            S_MV_WR_DN:
            begin
                cmd.wr_op  = WR_MOVE;
                cmd.k_inc  = 1'b1;
                state_next = S_MV_RD_DN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = st_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            st_reg        <= ST_BOOKED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/interval_booking_table.sv */
// Top level of the interval booking table: controller, datapath and checks.
// Keeps a sorted table of disjoint half-open intervals [start, end) in a
// memory of MAX_INTERVALS entries with one read port and one write port and
// books one request per transfer. Each request returns one result: booked,
// overlap, table full or empty/reversed range, plus the entry count after the
// request. Steps per request: an empty or reversed range goes through accept,
// range check and result load. Any other request goes through accept, range
// check, merge decision and result load, plus a read and a compare per stored
// entry compared (the scan stops at the first entry lying after the request),
// plus an end check when the scan runs to the end of the table. An overlap
// ends at the entry that overlaps and skips the decision step. An insertion
// adds a read and a write per entry shifted up, a last shift check and the
// write of the new entry; a join that removes an entry adds a read and a
// write per entry shifted down, a last check and the count update. The
// memory's single read and write port set this, since each shift moves one
// entry through the registered read data. The result step stretches while an
// earlier result still waits at the output. A new request is taken only while
// the block is idle; a finished result may wait at the output while the next
// request is already accepted. No clearing pass is needed after reset:
// entries are only read below the entry count.
module interval_booking_table #(
    parameter int MAX_INTERVALS = 64,
    parameter int TIME_BITS     = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] range_start,
    input  logic [31:0] range_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [6:0]  entries_in_use
);
    import ibt_pkg::*;

    `include "interval_booking_table_assert.svh"

    localparam int CW = $clog2(MAX_INTERVALS + 1);

    cmd_t          cmd;
    sts_t          sts;
    logic [CW-1:0] count;

    // sequencing of scan, merge and shift steps
    ibt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // interval memory, compares and result registers
    ibt_dp #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .TIME_BITS     (TIME_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .range_start    (range_start),
        .range_end      (range_end),
        .cmd            (cmd),
        .sts            (sts),
        .status         (status),
        .entries_in_use (entries_in_use),
        .count          (count)
    );

    // table never holds more entries than it has room for
    `IBT_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count <= CW'(MAX_INTERVALS))
    // an accepted request keeps the block busy for the next cycle
    `IBT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // a full refusal only happens with every entry in use
    `IBT_ASSERT_IMPL(a_full_means_full, clk, rst_n, cmd.res_load && cmd.res_status == ST_FULL,
                     count == CW'(MAX_INTERVALS))

endmodule

/* dv/interval_booking_table_tb.sv */
// Self-checking testbench for the interval booking table.
module interval_booking_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ibt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int RANDOM_ITEMS = 800;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] used;
    } booking_result_t;

    // Tracks the booked intervals and the results still owed by the block.
    class booking_scoreboard;
        logic [31:0] starts[TABLE_DEPTH];
        logic [31:0] ends[TABLE_DEPTH];
        int count;
        booking_result_t pending[$];
        int errors;
        int booked_cnt;
        int overlap_cnt;
        int full_cnt;
        int invalid_cnt;

        function new();
            count = 0;
            errors = 0;
            booked_cnt = 0;
            overlap_cnt = 0;
            full_cnt = 0;
            invalid_cnt = 0;
        endfunction

        // Book one request on the shadow table.
        function logic [1:0] book(logic [31:0] s, logic [31:0] e);
            int i;
            int k;
            bit jp;
            bit jn;
            if (s >= e)
                return ST_INVALID;
            for (i = 0; i < count; i++)
            begin
                if (s < ends[i] && e > starts[i])
                    return ST_OVERLAP;
                if (e <= starts[i])
                    break;
            end
            jp = (i > 0) && (ends[i - 1] == s);
            jn = (i < count) && (starts[i] == e);
            if (jp && jn)
            begin
                ends[i - 1] = ends[i];
                for (k = i; k + 1 < count; k++)
                begin
                    starts[k] = starts[k + 1];
                    ends[k] = ends[k + 1];
                end
                count--;
            end
            else if (jp)
                ends[i - 1] = e;
            else if (jn)
                starts[i] = s;
            else
            begin
                if (count >= TABLE_DEPTH)
                    return ST_FULL;
                for (k = count; k > i; k--)
                begin
                    starts[k] = starts[k - 1];
                    ends[k] = ends[k - 1];
                end
                starts[i] = s;
                ends[i] = e;
                count++;
            end
            return ST_BOOKED;
        endfunction

        function void note_request(logic [31:0] s, logic [31:0] e);
            booking_result_t r;
            r.status = book(s, e);
            r.used = count[6:0];
            case (r.status)
                ST_BOOKED:  booked_cnt++;
                ST_OVERLAP: overlap_cnt++;
                ST_FULL:    full_cnt++;
                default:    invalid_cnt++;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [6:0] used);
            booking_result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected result: status=%0d entries_in_use=%0d", st, used);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (st !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, st);
                errors++;
            end
            if (used !== exp_r.used)
            begin
                $error("entries_in_use: expected %0d, got %0d", exp_r.used, used);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [6:0]  entries_in_use;

    booking_scoreboard sb;
    longint cycle_cnt;
    // When set, both sides run with no idle cycles.
    bit no_idle;

    interval_booking_table dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .range_start    (range_start),
        .range_end      (range_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .entries_in_use (entries_in_use)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: ends a hung run.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stalls on out_ready, check on every transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(status, entries_in_use);
            out_ready <= no_idle || ($urandom_range(99) >= 13);
        end
    end

    // Present one request and hold it until the transfer happens.
    // Valid stays high after a transfer; it drops only for idle cycles.
    task automatic send_request(logic [31:0] s, logic [31:0] e);
        if (!no_idle && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 13)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        range_start <= s;
        range_end <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(s, e);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Mostly well-formed bookings near existing edges so merges and joins happen.
    task automatic send_random();
        logic [31:0] s;
        logic [31:0] e;
        int idx;
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            s = $urandom();
            e = $urandom();
        end
        else if (pick < 45 && sb.count > 0)
        begin
            // touch a neighbor edge
            idx = $urandom_range(sb.count - 1);
            if ($urandom_range(1))
            begin
                s = sb.ends[idx];
                e = s + $urandom_range(1, 6);
            end
            else
            begin
                e = sb.starts[idx];
                s = e - $urandom_range(1, 6);
            end
        end
        else if (pick < 55 && sb.count > 1)
        begin
            // exact gap fill joins two entries
            idx = $urandom_range(sb.count - 2);
            s = sb.ends[idx];
            e = sb.starts[idx + 1];
        end
        else
        begin
            s = $urandom_range(0, 2000);
            e = s + $urandom_range(0, 12);
            if (pick > 96)
            begin
                s = s | 32'hFFFF_F000;
                e = e | 32'hFFFF_F000;
            end
        end
        send_request(s, e);
    endtask

    initial
    begin
        int n;
        sb = new();
        cycle_cnt = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        range_start = '0;
        range_end = '0;
        out_ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: invalid ranges, extremes, merges, overlap.
        send_request(32'd10, 32'd10);
        send_request(32'd20, 32'd5);
        send_request(32'hFFFF_FFFF, 32'd0);
        send_request(32'd0, 32'd1);
        send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_request(32'd100, 32'd110);
        send_request(32'd105, 32'd106);
        send_request(32'd90, 32'd101);
        send_request(32'd110, 32'd120);
        send_request(32'd90, 32'd100);
        send_request(32'd130, 32'd140);
        send_request(32'd120, 32'd130);
        send_request(32'd1, 32'd90);
        send_request(32'hAAAA_AAAA, 32'hD555_5555);
        send_request(32'h5555_5555, 32'h5555_5556);
        send_request(32'd0, 32'hFFFF_FFFF);
        wait_drained();

        // Fill the table, then hit the full-table refusal and merges while full.
        for (n = 0; n < TABLE_DEPTH + 2; n++)
            send_request(32'h1000_0000 + 32'(n * 4), 32'h1000_0000 + 32'(n * 4 + 2));
        send_request(32'h1000_0002, 32'h1000_0003);
        send_request(32'h1000_0003, 32'h1000_0004);
        send_request(32'h0FFF_FFF0, 32'h0FFF_FFF1);
        wait_drained();

        // Random phase, with a back-to-back stretch in the middle.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n >= 300 && n < 420);
            if (n == 500)
                wait_drained();
            send_random();
        end
        no_idle = 1'b0;
        wait_drained();

        $display("Covered %0d booked, %0d overlap, %0d full, %0d invalid requests;",
                 sb.booked_cnt, sb.overlap_cnt, sb.full_cnt, sb.invalid_cnt);
        $display("final table holds %0d intervals.", sb.count);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
